// ===== hdl/rrd_pkg.sv =====
// Package for the run-length rectangle pixel decoder: types, codes and constants.
// Used by every module and the checker of the block; depends on nothing.
`default_nettype none

package rrd_pkg;

   // Reset values of the canvas size registers
   localparam logic [8:0] CANVAS_W_RST = 9'd320;
   localparam logic [7:0] CANVAS_H_RST = 8'd240;

   // Largest accepted rectangle area, default of the top-level parameter
   localparam int MAX_RECT_PIXELS_DEF = 320 * 16;

   // Tags at or above this value code a repeated pixel
   localparam logic [7:0] TAG_RUN_BASE = 8'd128;
   // Repeat count of a run tag is the tag minus this bias
   localparam logic [7:0] RUN_BIAS     = 8'd126;

   // Header is eight bytes; the last one is consumed without being stored
   localparam int HDR_BYTES = 8;
   localparam logic [2:0] HDR_LAST_POS = 3'(HDR_BYTES - 1);

   // Result queue between the parser and the output stage
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Configuration register indexes
   localparam logic CSR_CANVAS_WIDTH  = 1'b0;
   localparam logic CSR_CANVAS_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      KIND_WINDOW   = 3'd0,
      KIND_PIXEL    = 3'd1,
      KIND_DONE     = 3'd2,
      KIND_BADRECT  = 3'd3,
      KIND_OVERFLOW = 3'd4,
      KIND_TRUNC    = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      PH_STOP   = 3'd0,
      PH_HEADER = 3'd1,
      PH_TAG    = 3'd2,
      PH_LIT_HI = 3'd3,
      PH_LIT_LO = 3'd4,
      PH_RUN_HI = 3'd5,
      PH_RUN_LO = 3'd6
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] win_x;
      logic [15:0] win_y;
      logic [15:0] win_w;
      logic [15:0] win_h;
      logic [15:0] pixel;
      logic [7:0]  run_length;
      logic        last;
   } result_type;

   // One accepted byte gives a main result, a frame-closing result, both, or neither
   typedef struct packed {
      logic       has_prim;
      result_type prim;
      logic       has_tail;
      kind_type   tail_kind;
   } entry_type;

endpackage

`default_nettype wire

// ===== hdl/rrd_if.sv =====
// Channel interfaces of the decoder: byte input channel and result channel.
// Depends on nothing; the result kind is carried as a plain three-bit field.
`default_nettype none

interface rrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;
   logic       frame_end;

   modport source (output valid, output data_byte, output frame_start, output frame_end,
                   input ready);
   modport sink   (input valid, input data_byte, input frame_start, input frame_end,
                   output ready);
endinterface

interface rrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [15:0] win_x;
   logic [15:0] win_y;
   logic [15:0] win_w;
   logic [15:0] win_h;
   logic [15:0] pixel;
   logic [7:0]  run_length;
   logic        last;

   modport source  (output valid, output kind, output win_x, output win_y, output win_w,
                    output win_h, output pixel, output run_length, output last,
                    input ready);
   modport sink    (input valid, input kind, input win_x, input win_y, input win_w,
                    input win_h, input pixel, input run_length, input last,
                    output ready);
   modport monitor (input valid, input ready, input kind, input win_x, input win_y,
                    input win_w, input win_h, input pixel, input run_length, input last);
endinterface

`default_nettype wire

// ===== hdl/rrd_front.sv =====
// Byte parser of the decoder: header collection, rectangle check, tag and pixel decode.
// Depends on rrd_pkg and rrd_req_if; pushes result entries toward rrd_fifo.
`default_nettype none

module rrd_front
   import rrd_pkg::*;
#(
   parameter int MAX_RECT_PIXELS = MAX_RECT_PIXELS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   rrd_req_if.sink         req_if,
   input  wire logic       q_full,
   input  wire logic [8:0] canvas_w,
   input  wire logic [7:0] canvas_h,
   output      logic       push,
   output      entry_type  push_entry
);

   localparam int PL_W = $clog2(MAX_RECT_PIXELS + 1);
   localparam int CW   = (PL_W > 8) ? PL_W : 8;

   phase_type        phase_ff, phase_in, ph0, ph1;
   logic [2:0]       hcnt_ff, hcnt_in, hc0, hc1;
   logic [PL_W-1:0]  pl_ff, pl_in, pl0, pl1;
   logic [7:0]       rl_ff, rl_in, rl0, rl1;
   logic [7:0]       held_ff, held_in;
   logic [7:0]       hdr_ff [HDR_BYTES-1];
   logic             hdr_we;

   logic             acc;
   logic [7:0]       b;
   logic [15:0]      x, y, w, h;
   logic [31:0]      area;
   logic             rect_bad;
   logic             is_lit;
   logic [7:0]       tag_cnt;
   logic             tag_over;
   logic             lit_last, run_last;
   logic [7:0]       rl_dec;
   logic [CW-1:0]    run_used;
   logic             close_frame;
   entry_type        ent;

   assign req_if.ready = ~q_full;
   assign acc = req_if.valid & ~q_full;
   assign b   = req_if.data_byte;

   // Frame start restarts the parser before the byte is looked at
   assign ph0 = req_if.frame_start ? PH_HEADER : phase_ff;
   assign hc0 = req_if.frame_start ? 3'd0 : hcnt_ff;
   assign pl0 = req_if.frame_start ? '0 : pl_ff;
   assign rl0 = req_if.frame_start ? 8'd0 : rl_ff;

   assign x    = {hdr_ff[1], hdr_ff[0]};
   assign y    = {hdr_ff[3], hdr_ff[2]};
   assign w    = {hdr_ff[5], hdr_ff[4]};
   assign h    = {b, hdr_ff[6]};
   assign area = 32'(w) * 32'(h);
   assign rect_bad = (area > 32'(MAX_RECT_PIXELS))
                  || ({1'b0, x} + {1'b0, w} > {8'd0, canvas_w})
                  || ({1'b0, y} + {1'b0, h} > {9'd0, canvas_h});

   assign is_lit   = b < TAG_RUN_BASE;
   assign tag_cnt  = is_lit ? b + 8'd1 : b - RUN_BIAS;
   assign tag_over = CW'(tag_cnt) > CW'(pl0);
   assign lit_last = pl0 == PL_W'(1);
   assign rl_dec   = rl0 - 8'd1;
   assign run_last = CW'(rl0) >= CW'(pl0);
   assign run_used = run_last ? CW'(pl0) : CW'(rl0);

   // Next state of the parser
   always_comb begin
      ph1     = ph0;
      hc1     = hc0;
      pl1     = pl0;
      rl1     = rl0;
      held_in = held_ff;
      hdr_we  = 1'b0;
      case (ph0)
         PH_HEADER: begin
            if (hc0 != HDR_LAST_POS) begin
               hdr_we = 1'b1;
               hc1    = hc0 + 3'd1;
            end else begin
               hc1 = 3'd0;
               if (w == 16'd0 || rect_bad) begin
                  ph1 = PH_STOP;
               end else if (area != 32'd0) begin
                  pl1 = area[PL_W-1:0];
                  ph1 = PH_TAG;
               end
            end
         end
         PH_TAG: begin
            if (tag_over) begin
               pl1 = '0;
               ph1 = PH_HEADER;
               hc1 = 3'd0;
            end else begin
               rl1 = tag_cnt;
               ph1 = is_lit ? PH_LIT_HI : PH_RUN_HI;
            end
         end
         PH_LIT_HI: begin
            held_in = b;
            ph1     = PH_LIT_LO;
         end
         PH_LIT_LO: begin
            rl1 = rl_dec;
            pl1 = pl0 - PL_W'(1);
            if (rl_dec == 8'd0 || lit_last) begin
               if (pl0 == PL_W'(1)) begin
                  ph1 = PH_HEADER;
                  hc1 = 3'd0;
               end else begin
                  ph1 = PH_TAG;
               end
            end else begin
               ph1 = PH_LIT_HI;
            end
         end
         PH_RUN_HI: begin
            held_in = b;
            ph1     = PH_RUN_LO;
         end
         PH_RUN_LO: begin
            pl1 = pl0 - run_used[PL_W-1:0];
            rl1 = 8'd0;
            if (pl0 == run_used[PL_W-1:0]) begin
               ph1 = PH_HEADER;
               hc1 = 3'd0;
            end else begin
               ph1 = PH_TAG;
            end
         end
         default: ph1 = PH_STOP;
      endcase
   end

   // Frame end closes any open frame
   assign close_frame = req_if.frame_end && (ph1 != PH_STOP);

   always_comb begin
      phase_in = ph1;
      hcnt_in  = hc1;
      pl_in    = pl1;
      rl_in    = rl1;
      if (close_frame) begin
         phase_in = PH_STOP;
         hcnt_in  = 3'd0;
         pl_in    = '0;
         rl_in    = 8'd0;
      end
   end

   // Results of the byte
   always_comb begin
      ent           = '0;
      ent.prim.kind = KIND_WINDOW;
      ent.tail_kind = KIND_TRUNC;
      case (ph0)
         PH_HEADER: begin
            if (hc0 == HDR_LAST_POS) begin
               ent.has_prim  = 1'b1;
               ent.prim.last = 1'b1;
               if (w == 16'd0) begin
                  ent.prim.kind = KIND_DONE;
               end else if (rect_bad) begin
                  ent.prim.kind = KIND_BADRECT;
               end else begin
                  ent.prim.kind  = KIND_WINDOW;
                  ent.prim.win_x = x;
                  ent.prim.win_y = y;
                  ent.prim.win_w = w;
                  ent.prim.win_h = h;
                  ent.prim.last  = area == 32'd0;
               end
            end
         end
         PH_TAG: begin
            if (tag_over) begin
               ent.has_prim  = 1'b1;
               ent.prim.kind = KIND_OVERFLOW;
               ent.prim.last = 1'b1;
            end
         end
         PH_LIT_LO: begin
            ent.has_prim        = 1'b1;
            ent.prim.kind       = KIND_PIXEL;
            ent.prim.pixel      = {held_ff, b};
            ent.prim.run_length = 8'd1;
            ent.prim.last       = lit_last;
         end
         PH_RUN_LO: begin
            ent.has_prim        = 1'b1;
            ent.prim.kind       = KIND_PIXEL;
            ent.prim.pixel      = {held_ff, b};
            ent.prim.run_length = rl0;
            ent.prim.last       = run_last;
         end
         default: ent.has_prim = 1'b0;
      endcase
      if (close_frame) begin
         ent.has_tail  = 1'b1;
         ent.tail_kind = (ph1 == PH_HEADER && hc1 == 3'd0) ? KIND_DONE : KIND_TRUNC;
      end
   end

   assign push       = acc & (ent.has_prim | ent.has_tail);
   assign push_entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STOP;
         hcnt_ff  <= 3'd0;
         pl_ff    <= '0;
         rl_ff    <= 8'd0;
         held_ff  <= 8'd0;
      end else if (acc) begin
         phase_ff <= phase_in;
         hcnt_ff  <= hcnt_in;
         pl_ff    <= pl_in;
         rl_ff    <= rl_in;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc && hdr_we) begin
         hdr_ff[hc0] <= b;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/rrd_fifo.sv =====
// Short result queue between the parser and the output stage.
// Depends on rrd_pkg for the entry type and depth.
`default_nettype none

module rrd_fifo
   import rrd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output      logic      full,
   output      logic      not_empty,
   output      entry_type head
);

   entry_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                    do_pop;

   assign full      = cnt_ff == FIFO_CNT_W'(FIFO_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head      = mem_ff[rd_ptr_ff];
   assign do_pop    = pop & not_empty;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !do_pop) begin
         cnt_in = cnt_ff + FIFO_CNT_W'(1);
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/rrd_back.sv =====
// Output stage: holds one queue entry and hands out its one or two results.
// Depends on rrd_pkg and rrd_rsp_if; pops entries from rrd_fifo.
`default_nettype none

module rrd_back
   import rrd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      q_not_empty,
   input  wire entry_type q_head,
   output      logic      q_pop,
   rrd_rsp_if.source      rsp_if
);

   result_type prim_ff;
   kind_type   tail_kind_ff;
   logic       prim_pend_ff, tail_pend_ff;
   logic       take, fire;
   result_type cur;

   assign fire  = (prim_pend_ff | tail_pend_ff) & rsp_if.ready;
   // Free for a new entry when empty, or when its only pending result leaves now
   assign take  = ~(prim_pend_ff | tail_pend_ff)
               | (rsp_if.ready & (prim_pend_ff ^ tail_pend_ff));
   assign q_pop = take & q_not_empty;

   always_comb begin
      cur      = '0;
      cur.kind = tail_kind_ff;
      cur.last = 1'b1;
      if (prim_pend_ff) begin
         cur = prim_ff;
      end
   end

   assign rsp_if.valid      = prim_pend_ff | tail_pend_ff;
   assign rsp_if.kind       = cur.kind;
   assign rsp_if.win_x      = cur.win_x;
   assign rsp_if.win_y      = cur.win_y;
   assign rsp_if.win_w      = cur.win_w;
   assign rsp_if.win_h      = cur.win_h;
   assign rsp_if.pixel      = cur.pixel;
   assign rsp_if.run_length = cur.run_length;
   assign rsp_if.last       = cur.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         prim_pend_ff <= 1'b0;
         tail_pend_ff <= 1'b0;
      end else if (q_pop) begin
         prim_pend_ff <= q_head.has_prim;
         tail_pend_ff <= q_head.has_tail;
      end else if (fire) begin
         if (prim_pend_ff) begin
            prim_pend_ff <= 1'b0;
         end else begin
            tail_pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         prim_ff      <= q_head.prim;
         tail_kind_ff <= q_head.tail_kind;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/rle_rect_pixel_decoder.sv =====
// Path: a result is written into the result queue at the edge that accepts its byte, then
//   loaded into the output stage, from which it is valid on rsp_if.
// Throughput: one byte per cycle while the result queue is not full; a byte with frame_end
//   that also closes an item gives two results, which leave one after the other through a four-entry result queue.
// Reset: synchronous, active high; canvas set to 320 x 240, parser stopped waiting for a
//   frame start, result queue and output stage emptied.
`default_nettype none

module rle_rect_pixel_decoder
   import rrd_pkg::*;
#(
   parameter int MAX_RECT_PIXELS = MAX_RECT_PIXELS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   rrd_req_if.sink         req_if,
   rrd_rsp_if.source       rsp_if,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [8:0] csr_wdata
);

   // Canvas size registers; the user must write them only while the decoder is idle (not enforced here)
   logic [8:0] canvas_w_ff;
   logic [7:0] canvas_h_ff;

   // Queue handshake between the parser (front) and the output stage (back)
   logic       push;
   entry_type  push_entry;
   logic       q_full;
   logic       q_not_empty;
   logic       q_pop;
   entry_type  q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_w_ff <= CANVAS_W_RST;
         canvas_h_ff <= CANVAS_H_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CANVAS_WIDTH:  canvas_w_ff <= csr_wdata;
            CSR_CANVAS_HEIGHT: canvas_h_ff <= csr_wdata[7:0];
            default:           canvas_w_ff <= canvas_w_ff;
         endcase
      end
   end

   // Front: accept one byte per cycle while the queue has room, advance the
   // parser and push the entry of results that the byte causes.
   rrd_front #(
      .MAX_RECT_PIXELS(MAX_RECT_PIXELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .q_full     (q_full),
      .canvas_w   (canvas_w_ff),
      .canvas_h   (canvas_h_ff),
      .push       (push),
      .push_entry (push_entry)
   );

   // Queue: absorb back-pressure on the result side and double-result bytes.
   rrd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   // Back: hold one entry and transfer its results in order.
   rrd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_if      (rsp_if)
   );

endmodule

`default_nettype wire

// ===== hdl/rrd_checker.sv =====
// Port-level checks of the decoder's result channel, attached to the top level by bind.
// Depends on rrd_pkg for result codes.
`default_nettype none

module rrd_checker
   import rrd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_kind,
   input wire logic [15:0] rsp_win_x,
   input wire logic [15:0] rsp_win_y,
   input wire logic [15:0] rsp_win_w,
   input wire logic [15:0] rsp_win_h,
   input wire logic [15:0] rsp_pixel,
   input wire logic [7:0]  rsp_run_length,
   input wire logic        rsp_last
);

   // Output stage is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Status results always close the rectangle or frame
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_DONE || rsp_kind == KIND_BADRECT ||
       rsp_kind == KIND_OVERFLOW || rsp_kind == KIND_TRUNC)) |-> rsp_last)
      else $error("status result without last");

   // Only window results carry a rectangle
   a_win_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_WINDOW) |->
      (rsp_win_x == 16'd0 && rsp_win_y == 16'd0 &&
       rsp_win_w == 16'd0 && rsp_win_h == 16'd0))
      else $error("rectangle fields set on a non-window result");

   // A pixel result always writes at least one pixel
   a_pixel_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_PIXEL) |-> rsp_run_length != 8'd0)
      else $error("pixel result with zero run length");

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_kind) && $stable(rsp_pixel)))
      else $error("stalled result changed");

endmodule

bind rle_rect_pixel_decoder rrd_checker u_rrd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_kind       (rsp_if.kind),
   .rsp_win_x      (rsp_if.win_x),
   .rsp_win_y      (rsp_if.win_y),
   .rsp_win_w      (rsp_if.win_w),
   .rsp_win_h      (rsp_if.win_h),
   .rsp_pixel      (rsp_if.pixel),
   .rsp_run_length (rsp_if.run_length),
   .rsp_last       (rsp_if.last)
);

`default_nettype wire
